>>> rtl/erld_pkg.sv
// Shared types, constants and helpers for the escape run-length decoder.
// Used by erld_decode, erld_expand and escape_run_length_decoder_top.
// No dependencies.
package erld_pkg;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 4;
    localparam int NIBBLE_W = 4;
    localparam int DICT_W   = 64;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] ESC_CODE        = 8'h07;
    localparam logic [BYTE_W-1:0] ESC_LITERAL_SEL = 8'h00;
    localparam logic [COUNT_W-1:0] COUNT_ONE      = 4'd1;
    localparam logic [COUNT_W-1:0] COUNT_ZERO     = 4'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DICT_LOWER = 1'b0,
        CFG_DICT_UPPER = 1'b1
    } cfg_idx_t;

    // One decoded job: a byte and how many times it is emitted.
    typedef struct packed {
        logic [BYTE_W-1:0]  val;
        logic [COUNT_W-1:0] count;
    } job_t;

    function automatic logic [BYTE_W-1:0] dict_entry(
        input logic [DICT_W-1:0]   lower,
        input logic [DICT_W-1:0]   upper,
        input logic [NIBBLE_W-1:0] sel
    );
        logic [DICT_W-1:0] word;
        word = sel[3] ? upper : lower;
        return word[{sel[2:0], 3'b000} +: BYTE_W];
    endfunction

endpackage

>>> rtl/erld_decode.sv
// Input stage: dictionary registers, escape tracking and the job register.
// Depends on erld_pkg.
module erld_decode import erld_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [DICT_W-1:0]     cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_byte,
    input  logic                  s_final,
    output logic                  job_valid,
    input  logic                  job_ready,
    output job_t                  job
);

    logic [DICT_W-1:0] dict_lower_reg;
    logic [DICT_W-1:0] dict_upper_reg;
    logic              pending_reg, pending_next;
    logic              job_valid_reg, job_valid_next;
    job_t              job_reg, job_next;
    job_t              dec;
    logic              accept;

    assign s_tready  = !job_valid_reg || job_ready;
    assign accept    = s_tvalid && s_tready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb begin
        dec          = '{val: s_byte, count: COUNT_ONE};
        pending_next = pending_reg;
        if (pending_reg) begin
            pending_next = 1'b0;
            if (s_byte == ESC_LITERAL_SEL) begin
                dec = '{val: ESC_CODE, count: COUNT_ONE};
            end else begin
                dec.val   = dict_entry(dict_lower_reg, dict_upper_reg, s_byte[NIBBLE_W-1:0]);
                dec.count = s_byte[BYTE_W-1 -: COUNT_W];
            end
        end else if (s_byte == ESC_CODE && !s_final) begin
            dec.count    = COUNT_ZERO;
            pending_next = 1'b1;
        end
    end

    always_comb begin
        job_valid_next = job_valid_reg && !job_ready;
        job_next       = job_reg;
        if (accept) begin
            job_valid_next = (dec.count != COUNT_ZERO);
            job_next       = dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dict_lower_reg <= '0;
            dict_upper_reg <= '0;
            pending_reg    <= 1'b0;
            job_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_DICT_LOWER: dict_lower_reg <= cfg_wdata;
                    CFG_DICT_UPPER: dict_upper_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                pending_reg <= pending_next;
            end
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
    end

endmodule

>>> rtl/erld_expand.sv
// Output stage: repeat counter and output register that expand one job into beats.
// Depends on erld_pkg.
module erld_expand import erld_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    output logic              job_ready,
    input  job_t              job,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_byte,
    output logic              m_last
);

    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [BYTE_W-1:0]  val_reg, val_next;
    logic               slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign job_ready = slot_free && (rem_reg == COUNT_ZERO);
    assign m_tvalid  = out_valid_reg;
    assign m_byte    = out_byte_reg;
    assign m_last    = out_last_reg;

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        rem_next       = rem_reg;
        val_next       = val_reg;
        if (slot_free) begin
            if (rem_reg != COUNT_ZERO) begin
                out_valid_next = 1'b1;
                out_byte_next  = val_reg;
                out_last_next  = (rem_reg == COUNT_ONE);
                rem_next       = rem_reg - COUNT_ONE;
            end else if (job_valid) begin
                out_valid_next = 1'b1;
                out_byte_next  = job.val;
                out_last_next  = (job.count == COUNT_ONE);
                rem_next       = job.count - COUNT_ONE;
                val_next       = job.val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            rem_reg       <= COUNT_ZERO;
        end else begin
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        val_reg      <= val_next;
    end

endmodule

>>> rtl/escape_run_length_decoder_top.sv
// Escape run-length decoder top level: a decode stage and an expand stage.
// A literal byte passes through the job register and then the output register on its way out.
// Literal bytes pass at one beat per cycle unless the output stalls; an escape operand
// with count n gives n beats, and the input stalls once the job register is full.
// Reset (aresetn low, synchronous) clears the dictionary, the pending escape and all valids.
// Depends on erld_pkg, erld_decode and erld_expand.
module escape_run_length_decoder_top import erld_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [DICT_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BYTE_W-1:0]    m_tdata,   // [7:0] out_byte
    output logic                 m_tlast
);

    logic job_valid;
    logic job_ready;
    job_t job;

    erld_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_byte    (s_tdata),
        .s_final   (s_tlast),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    erld_expand u_expand (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_byte    (m_tdata),
        .m_last    (m_tlast)
    );

endmodule
